FILE: rtl/core/gssl_pkg.sv
// gssl_pkg: shared types and constants of the greedy superstring length unit
// command and status groups between controller and datapath
// no dependencies
`default_nettype none

package gssl_pkg;

   // result field width and saturation limit
   localparam int unsigned RESULT_W = 11;
   localparam logic [RESULT_W-1:0] LEN_SAT = 11'h7FF;

   // datapath operations issued by the controller
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROUND_INIT,
      OP_SCAN,
      OP_PAIR_INIT,
      OP_LOAD_I,
      OP_LOAD_J,
      OP_CT_READ,
      OP_CT_NEXT_OFF,
      OP_CT_NEXT_C,
      OP_SP_INIT,
      OP_SP_READ,
      OP_SP_NEXT_K,
      OP_SP_NEXT_C,
      OP_TAKE_CT,
      OP_TAKE_SP,
      OP_TAKE_ZERO,
      OP_NEXT_J,
      OP_NEXT_I,
      OP_M_LOAD_I,
      OP_M_LOAD_J,
      OP_CP_READ,
      OP_CP_WRITE,
      OP_SET_LEN,
      OP_CLEAR_J,
      OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic len_zero;
      logic j_eq_i;
      logic pruned;
      logic lj_le_li;
      logic chars_eq;
      logic off_end;
      logic ct_c_last;
      logic k_stop;
      logic best_none;
      logic sp_c_last;
      logic babs;
      logic copy_done;
      logic live_le1;
      logic s_last;
      logic i_last;
      logic j_last;
   } sts_type;

endpackage

`default_nettype wire

FILE: rtl/core/greedy_superstring_length_unit.sv
// greedy_superstring_length_unit: top level, controller plus datapath
// depends on gssl_pkg, gssl_controller, gssl_datapath
//
//   channel   ports                                        handshake
//   request   req_char_code, req_end_of_string,            start, busy
//             req_end_of_set
//   response  rsp_superstring_length, rsp_overflow         rsp_valid strobe
//
// characters load one per cycle while busy is low
// a beat with end of set raises busy; each merge round scans all slots,
// visits every ordered pair, compares characters for each overlap length
// tried, and copies each character in check, read and write steps, since
// store reads are registered
// the result beat shows for one cycle as busy falls; the receiver cannot stall
// synchronous reset clears lengths, counters and flags; the store is not cleared
`default_nettype none

module greedy_superstring_length_unit
   import gssl_pkg::*;
#(
   parameter int unsigned MAX_STRINGS = 16,
   parameter int unsigned SLOT_LEN    = 1024
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  start,
   output logic                 busy,
   input  wire  [7:0]           req_char_code,
   input  wire                  req_end_of_string,
   input  wire                  req_end_of_set,
   output logic                 rsp_valid,
   output logic [RESULT_W-1:0]  rsp_superstring_length,
   output logic                 rsp_overflow
);

   cmd_type cmd;
   sts_type sts;

   gssl_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_end_of_set (req_end_of_set),
      .sts            (sts),
      .cmd            (cmd),
      .busy           (busy),
      .rsp_valid      (rsp_valid)
   );

   gssl_datapath #(
      .MAX_STRINGS (MAX_STRINGS),
      .SLOT_LEN    (SLOT_LEN)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .sts                    (sts),
      .req_char_code          (req_char_code),
      .req_end_of_string      (req_end_of_string),
      .req_end_of_set         (req_end_of_set),
      .rsp_superstring_length (rsp_superstring_length),
      .rsp_overflow           (rsp_overflow)
   );

   // result beat is a single cycle strobe
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held");

   // a beat that does not close the set keeps the block loading
   a_load_stays: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_end_of_set) |=> (!busy && !rsp_valid))
      else $error("plain character beat left loading");

   // result shows as busy falls
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result beat while busy");

endmodule

`default_nettype wire

FILE: rtl/core/gssl_ram.sv
// gssl_ram: generic ram, one write port and two registered read ports
// no dependencies
`default_nettype none

module gssl_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16384
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire  [$clog2(DEPTH)-1:0] waddr,
   input  wire  [WIDTH-1:0]         wdata,
   input  wire  [$clog2(DEPTH)-1:0] raddr_a,
   output logic [WIDTH-1:0]         rdata_a,
   input  wire  [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

`default_nettype wire

FILE: rtl/core/gssl_datapath.sv
// gssl_datapath: slot lengths, pair search counters, character store and result
// depends on gssl_pkg and gssl_ram
`default_nettype none

module gssl_datapath
   import gssl_pkg::*;
#(
   parameter int unsigned MAX_STRINGS = 16,
   parameter int unsigned SLOT_LEN    = 1024
) (
   input  wire                  clock,
   input  wire                  reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  wire  [7:0]           req_char_code,
   input  wire                  req_end_of_string,
   input  wire                  req_end_of_set,
   output logic [RESULT_W-1:0]  rsp_superstring_length,
   output logic                 rsp_overflow
);

   localparam int unsigned IW    = (MAX_STRINGS > 1) ? $clog2(MAX_STRINGS) : 1;
   localparam int unsigned CW    = $clog2(MAX_STRINGS + 1);
   localparam int unsigned LW    = $clog2(SLOT_LEN + 1);
   localparam int unsigned DEPTH = MAX_STRINGS * SLOT_LEN;
   localparam int unsigned AW    = $clog2(DEPTH);
   localparam int unsigned XW    = LW + RESULT_W;

   // string bookkeeping
   logic [LW-1:0] slot_len_ff [MAX_STRINGS];
   logic [CW-1:0] count_ff;
   logic [LW-1:0] fill_ff;
   logic          ovf_ff;

   // round and pair search state
   logic [IW-1:0] s_ff, i_ff, j_ff, bi_ff, bj_ff;
   logic [1:0]    live_ff;
   logic [LW-1:0] sum_ff, li_ff, lj_ff, off_ff, c_ff, k_ff, add_ff, best_ff;
   logic          best_none_ff, babs_ff;

   // result beat
   logic [RESULT_W-1:0] rsp_len_ff;
   logic                rsp_ovf_ff;

   logic [IW-1:0]  len_sel;
   logic [LW-1:0]  len_rd;
   logic           store_ok;
   logic [LW-1:0]  fill_next;
   logic [AW-1:0]  raddr_a, raddr_b, waddr;
   logic [7:0]     wdata, rdata_a, rdata_b;
   logic           we;
   logic [LW-1:0]  add_raw;
   logic [LW:0]    merged_len;
   logic [XW-1:0]  sum_ext;

   function automatic logic [AW-1:0] slot_base(input logic [IW-1:0] idx);
      slot_base = AW'(idx) * AW'(SLOT_LEN);
   endfunction

   // single read of the slot length table
   always_comb begin
      unique case (cmd.op)
         OP_SCAN:     len_sel = s_ff;
         OP_LOAD_I:   len_sel = i_ff;
         OP_M_LOAD_I: len_sel = bi_ff;
         OP_M_LOAD_J: len_sel = bj_ff;
         default:     len_sel = j_ff;
      endcase
   end
   assign len_rd = slot_len_ff[len_sel];

   // load beat
   assign store_ok  = (count_ff < CW'(MAX_STRINGS)) && (fill_ff < LW'(SLOT_LEN));
   assign fill_next = store_ok ? fill_ff + LW'(1) : fill_ff;

   // merge length with clipping to the slot
   assign add_raw    = len_rd - best_ff;
   assign merged_len = {1'b0, li_ff} + {1'b0, add_raw};

   // store addresses
   always_comb begin
      raddr_a = slot_base(i_ff) + AW'(off_ff) + AW'(c_ff);
      raddr_b = slot_base(j_ff) + AW'(c_ff);
      if (cmd.op == OP_SP_READ) begin
         raddr_a = slot_base(i_ff) + AW'(li_ff - k_ff) + AW'(c_ff);
      end
      if (cmd.op == OP_CP_READ) begin
         raddr_b = slot_base(bj_ff) + AW'(best_ff) + AW'(c_ff);
      end
      if (cmd.op == OP_CP_WRITE) begin
         we    = 1'b1;
         waddr = slot_base(bi_ff) + AW'(li_ff) + AW'(c_ff);
         wdata = rdata_b;
      end else begin
         we    = (cmd.op == OP_LOAD) && store_ok;
         waddr = slot_base(IW'(count_ff)) + AW'(fill_ff);
         wdata = req_char_code;
      end
   end

   gssl_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .we      (we),
      .waddr   (waddr),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .rdata_a (rdata_a),
      .raddr_b (raddr_b),
      .rdata_b (rdata_b)
   );

   // status towards the controller
   always_comb begin
      sts.len_zero  = (len_rd == '0);
      sts.j_eq_i    = (j_ff == i_ff);
      sts.pruned    = !best_none_ff && (len_rd <= best_ff);
      sts.lj_le_li  = (len_rd <= li_ff);
      sts.chars_eq  = (rdata_a == rdata_b);
      sts.off_end   = (off_ff == li_ff - lj_ff);
      sts.ct_c_last = (c_ff == lj_ff - LW'(1));
      sts.k_stop    = (k_ff == '0) || (!best_none_ff && (k_ff <= best_ff));
      sts.best_none = best_none_ff;
      sts.sp_c_last = (c_ff == k_ff - LW'(1));
      sts.babs      = babs_ff;
      sts.copy_done = (c_ff == add_ff);
      sts.live_le1  = !live_ff[1];
      sts.s_last    = (s_ff == IW'(MAX_STRINGS - 1));
      sts.i_last    = (i_ff == IW'(MAX_STRINGS - 1));
      sts.j_last    = (j_ff == IW'(MAX_STRINGS - 1));
   end

   // saturated result length
   assign sum_ext = XW'(sum_ff);

   // operation execution
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < MAX_STRINGS; n++) begin
            slot_len_ff[n] <= '0;
         end
         count_ff <= '0;
         fill_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         unique case (cmd.op)
            OP_LOAD: begin
               if (!store_ok) begin
                  ovf_ff <= 1'b1;
               end
               fill_ff <= fill_next;
               if (req_end_of_string || req_end_of_set) begin
                  fill_ff <= '0;
                  if (count_ff < CW'(MAX_STRINGS)) begin
                     slot_len_ff[IW'(count_ff)] <= fill_next;
                     count_ff <= count_ff + CW'(1);
                  end else begin
                     ovf_ff <= 1'b1;
                  end
               end
            end
            OP_ROUND_INIT: begin
               s_ff    <= '0;
               live_ff <= 2'd0;
               sum_ff  <= '0;
            end
            OP_SCAN: begin
               if (len_rd != '0) begin
                  live_ff <= live_ff[1] ? 2'd2 : live_ff + 2'd1;
               end
               sum_ff <= sum_ff | len_rd;
               s_ff   <= s_ff + IW'(1);
            end
            OP_PAIR_INIT: begin
               i_ff         <= '0;
               best_none_ff <= 1'b1;
               babs_ff      <= 1'b0;
            end
            OP_LOAD_I: begin
               li_ff <= len_rd;
               j_ff  <= '0;
            end
            OP_LOAD_J: begin
               lj_ff  <= len_rd;
               off_ff <= '0;
               c_ff   <= '0;
            end
            OP_CT_NEXT_OFF: begin
               off_ff <= off_ff + LW'(1);
               c_ff   <= '0;
            end
            OP_CT_NEXT_C, OP_SP_NEXT_C: begin
               c_ff <= c_ff + LW'(1);
            end
            OP_SP_INIT: begin
               k_ff <= (li_ff <= lj_ff) ? li_ff : lj_ff;
               c_ff <= '0;
            end
            OP_SP_NEXT_K: begin
               k_ff <= k_ff - LW'(1);
               c_ff <= '0;
            end
            OP_TAKE_CT, OP_TAKE_SP, OP_TAKE_ZERO: begin
               best_none_ff <= 1'b0;
               bi_ff        <= i_ff;
               bj_ff        <= j_ff;
               babs_ff      <= (cmd.op == OP_TAKE_CT);
               if (cmd.op == OP_TAKE_CT) begin
                  best_ff <= lj_ff;
               end else if (cmd.op == OP_TAKE_SP) begin
                  best_ff <= k_ff;
               end else begin
                  best_ff <= '0;
               end
            end
            OP_NEXT_J: begin
               j_ff <= j_ff + IW'(1);
            end
            OP_NEXT_I: begin
               i_ff <= i_ff + IW'(1);
            end
            OP_M_LOAD_I: begin
               li_ff <= len_rd;
            end
            OP_M_LOAD_J: begin
               c_ff <= '0;
               if (merged_len > (LW + 1)'(SLOT_LEN)) begin
                  ovf_ff <= 1'b1;
                  add_ff <= LW'(SLOT_LEN) - li_ff;
               end else begin
                  add_ff <= add_raw;
               end
            end
            OP_CP_WRITE: begin
               c_ff <= c_ff + LW'(1);
            end
            OP_SET_LEN: begin
               slot_len_ff[bi_ff] <= li_ff + add_ff;
            end
            OP_CLEAR_J: begin
               slot_len_ff[bj_ff] <= '0;
            end
            OP_EMIT: begin
               rsp_len_ff <= (sum_ext > XW'(LEN_SAT)) ? LEN_SAT : sum_ext[RESULT_W-1:0];
               rsp_ovf_ff <= ovf_ff;
               for (int n = 0; n < MAX_STRINGS; n++) begin
                  slot_len_ff[n] <= '0;
               end
               count_ff <= '0;
               fill_ff  <= '0;
               ovf_ff   <= 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_superstring_length = rsp_len_ff;
   assign rsp_overflow           = rsp_ovf_ff;

endmodule

`default_nettype wire

FILE: rtl/core/gssl_controller.sv
// gssl_controller: sequencer for loading, pair search and merging
// depends on gssl_pkg
`default_nettype none

module gssl_controller
   import gssl_pkg::*;
(
   input  wire      clock,
   input  wire      reset,
   input  wire      start,
   input  wire      req_end_of_set,
   input  sts_type  sts,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_valid
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROUND,
      ST_SCAN,
      ST_DECIDE,
      ST_PI,
      ST_PJ,
      ST_CT_RD,
      ST_CT_CMP,
      ST_SP_INIT,
      ST_SP_CHK,
      ST_SP_RD,
      ST_SP_CMP,
      ST_NEXT_J,
      ST_NEXT_I,
      ST_M_LI,
      ST_M_LJ,
      ST_CP_CHK,
      ST_CP_RD,
      ST_CP_WR,
      ST_SET_LEN,
      ST_CLEAR
   } state_type;

   state_type state_ff;
   logic      busy_ff;
   logic      rsp_valid_ff;

   // operation decode
   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE:    cmd.op = start ? OP_LOAD : OP_NONE;
         ST_ROUND:   cmd.op = OP_ROUND_INIT;
         ST_SCAN:    cmd.op = OP_SCAN;
         ST_DECIDE:  cmd.op = sts.live_le1 ? OP_EMIT : OP_PAIR_INIT;
         ST_PI:      cmd.op = OP_LOAD_I;
         ST_PJ:      cmd.op = OP_LOAD_J;
         ST_CT_RD:   cmd.op = OP_CT_READ;
         ST_CT_CMP: begin
            if (!sts.chars_eq) begin
               cmd.op = sts.off_end ? OP_NONE : OP_CT_NEXT_OFF;
            end else begin
               cmd.op = sts.ct_c_last ? OP_TAKE_CT : OP_CT_NEXT_C;
            end
         end
         ST_SP_INIT: cmd.op = OP_SP_INIT;
         ST_SP_CHK:  cmd.op = (sts.k_stop && sts.best_none) ? OP_TAKE_ZERO : OP_NONE;
         ST_SP_RD:   cmd.op = OP_SP_READ;
         ST_SP_CMP: begin
            if (!sts.chars_eq) begin
               cmd.op = OP_SP_NEXT_K;
            end else begin
               cmd.op = sts.sp_c_last ? OP_TAKE_SP : OP_SP_NEXT_C;
            end
         end
         ST_NEXT_J:  cmd.op = sts.j_last ? OP_NONE : OP_NEXT_J;
         ST_NEXT_I:  cmd.op = sts.i_last ? OP_NONE : OP_NEXT_I;
         ST_M_LI:    cmd.op = OP_M_LOAD_I;
         ST_M_LJ:    cmd.op = OP_M_LOAD_J;
         ST_CP_CHK:  cmd.op = OP_NONE;
         ST_CP_RD:   cmd.op = OP_CP_READ;
         ST_CP_WR:   cmd.op = OP_CP_WRITE;
         ST_SET_LEN: cmd.op = OP_SET_LEN;
         ST_CLEAR:   cmd.op = OP_CLEAR_J;
         default:    cmd.op = OP_NONE;
      endcase
   end

   // state, busy and result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start && req_end_of_set) begin
                  state_ff <= ST_ROUND;
                  busy_ff  <= 1'b1;
               end
            end
            ST_ROUND: state_ff <= ST_SCAN;
            ST_SCAN: begin
               if (sts.s_last) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (sts.live_le1) begin
                  state_ff     <= ST_IDLE;
                  busy_ff      <= 1'b0;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= ST_PI;
               end
            end
            ST_PI: state_ff <= sts.len_zero ? ST_NEXT_I : ST_PJ;
            ST_PJ: begin
               priority if (sts.j_eq_i || sts.len_zero || sts.pruned) begin
                  state_ff <= ST_NEXT_J;
               end else if (sts.lj_le_li) begin
                  state_ff <= ST_CT_RD;
               end else begin
                  state_ff <= ST_SP_INIT;
               end
            end
            ST_CT_RD: state_ff <= ST_CT_CMP;
            ST_CT_CMP: begin
               priority if (!sts.chars_eq && sts.off_end) begin
                  state_ff <= ST_SP_INIT;
               end else if (sts.chars_eq && sts.ct_c_last) begin
                  state_ff <= ST_NEXT_J;
               end else begin
                  state_ff <= ST_CT_RD;
               end
            end
            ST_SP_INIT: state_ff <= ST_SP_CHK;
            ST_SP_CHK:  state_ff <= sts.k_stop ? ST_NEXT_J : ST_SP_RD;
            ST_SP_RD:   state_ff <= ST_SP_CMP;
            ST_SP_CMP: begin
               priority if (!sts.chars_eq) begin
                  state_ff <= ST_SP_CHK;
               end else if (sts.sp_c_last) begin
                  state_ff <= ST_NEXT_J;
               end else begin
                  state_ff <= ST_SP_RD;
               end
            end
            ST_NEXT_J:  state_ff <= sts.j_last ? ST_NEXT_I : ST_PJ;
            ST_NEXT_I:  state_ff <= sts.i_last ? ST_M_LI : ST_PI;
            ST_M_LI:    state_ff <= sts.babs ? ST_CLEAR : ST_M_LJ;
            ST_M_LJ:    state_ff <= ST_CP_CHK;
            ST_CP_CHK:  state_ff <= sts.copy_done ? ST_SET_LEN : ST_CP_RD;
            ST_CP_RD:   state_ff <= ST_CP_WR;
            ST_CP_WR:   state_ff <= ST_CP_CHK;
            ST_SET_LEN: state_ff <= ST_CLEAR;
            ST_CLEAR:   state_ff <= ST_ROUND;
            default:    state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

   // busy is low exactly while loading
   a_busy_idle: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (state_ff != ST_IDLE))
      else $error("busy disagrees with controller state");

   // closing a set always starts the merge
   a_set_starts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && req_end_of_set) |=> (state_ff == ST_ROUND))
      else $error("end of set did not start merge");

   // a result beat comes only out of the round decision
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ($past(state_ff) == ST_DECIDE && state_ff == ST_IDLE))
      else $error("result beat without a finished merge");

endmodule

`default_nettype wire

FILE: test/greedy_superstring_length_unit_tb.sv
// greedy_superstring_length_unit_tb: self-checking bench for the superstring length unit
// loads directed and random string sets, predicts the greedy merge length and overflow flag in a scoreboard
// depends on gssl_pkg and greedy_superstring_length_unit
`default_nettype none

module greedy_superstring_length_unit_tb
   import gssl_pkg::*;
();

   localparam int unsigned NUM_SLOTS = 16;
   localparam int unsigned SLOT_CHARS = 1024;

   typedef struct {
      int unsigned len;
      bit          ovf;
   } length_result_type;

   // greedy merge predictor plus queue of pending lengths
   class superstring_scoreboard_type;
      logic [7:0]        slot_chars [NUM_SLOTS][SLOT_CHARS];
      int unsigned       slot_len [NUM_SLOTS];
      int unsigned       closed_count;
      int unsigned       fill_pos;
      bit                ovf_seen;
      length_result_type pending_lengths [$];
      int                errors;

      function void clear_set();
         foreach (slot_len[s]) slot_len[s] = 0;
         closed_count = 0;
         fill_pos = 0;
         ovf_seen = 1'b0;
      endfunction

      function bit holds(int unsigned a, int unsigned b);
         int unsigned la, lb;
         bit same;
         la = slot_len[a];
         lb = slot_len[b];
         if (lb > la) return 1'b0;
         for (int unsigned p = 0; p + lb <= la; p++) begin
            same = 1'b1;
            for (int unsigned c = 0; c < lb && same; c++)
               if (slot_chars[a][p+c] !== slot_chars[b][c]) same = 1'b0;
            if (same) return 1'b1;
         end
         return 1'b0;
      endfunction

      function int unsigned overlap(int unsigned a, int unsigned b);
         int unsigned la, k;
         bit same;
         la = slot_len[a];
         k = (la < slot_len[b]) ? la : slot_len[b];
         for (; k > 0; k--) begin
            same = 1'b1;
            for (int unsigned c = 0; c < k && same; c++)
               if (slot_chars[a][la-k+c] !== slot_chars[b][c]) same = 1'b0;
            if (same) return k;
         end
         return 0;
      endfunction

      // repeated best-pair merge until one slot is left
      function int unsigned merged_length();
         int unsigned live, last, bi, bj, sc, li, add, k;
         int best;
         bit babs, ab;
         forever begin
            live = 0;
            last = 0;
            for (int unsigned i = 0; i < NUM_SLOTS; i++)
               if (slot_len[i] > 0) begin
                  live++;
                  last = i;
               end
            if (live <= 1) return live ? slot_len[last] : 0;
            best = -1;
            bi = 0;
            bj = 0;
            babs = 1'b0;
            for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
               if (slot_len[i] == 0) continue;
               for (int unsigned j = 0; j < NUM_SLOTS; j++) begin
                  if (i == j || slot_len[j] == 0) continue;
                  ab = holds(i, j);
                  sc = ab ? slot_len[j] : overlap(i, j);
                  if (int'(sc) > best) begin
                     best = int'(sc);
                     bi = i;
                     bj = j;
                     babs = ab;
                  end
               end
            end
            if (!babs) begin
               k = unsigned'(best);
               li = slot_len[bi];
               add = slot_len[bj] - k;
               if (li + add > SLOT_CHARS) begin
                  ovf_seen = 1'b1;
                  add = SLOT_CHARS - li;
               end
               for (int unsigned c = 0; c < add; c++)
                  slot_chars[bi][li+c] = slot_chars[bj][k+c];
               slot_len[bi] = li + add;
            end
            slot_len[bj] = 0;
         end
      endfunction

      function void note_beat(logic [7:0] ch, bit eos, bit eoset);
         length_result_type r;
         int unsigned len;
         if (closed_count >= NUM_SLOTS || fill_pos >= SLOT_CHARS) begin
            ovf_seen = 1'b1;
         end else begin
            slot_chars[closed_count][fill_pos] = ch;
            fill_pos++;
         end
         // closing a string, or dropping it when all slots are taken
         if (eos || eoset) begin
            if (closed_count < NUM_SLOTS) begin
               slot_len[closed_count] = fill_pos;
               closed_count++;
            end else begin
               ovf_seen = 1'b1;
            end
            fill_pos = 0;
         end
         if (eoset) begin
            len = merged_length();
            r.len = (len > 2047) ? 2047 : len;
            r.ovf = ovf_seen;
            pending_lengths.push_back(r);
            clear_set();
         end
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check_result(logic [RESULT_W-1:0] len, logic ovf);
         length_result_type r;
         if (pending_lengths.size() == 0) begin
            report($sformatf("unexpected result length %0d overflow %0b", len, ovf));
         end else begin
            r = pending_lengths.pop_front();
            if (len !== r.len[RESULT_W-1:0])
               report($sformatf("length %0d, expected %0d", len, r.len));
            if (ovf !== r.ovf)
               report($sformatf("overflow %0b, expected %0b", ovf, r.ovf));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [7:0]          req_char_code;
   logic                req_end_of_string;
   logic                req_end_of_set;
   logic                rsp_valid;
   logic [RESULT_W-1:0] rsp_superstring_length;
   logic                rsp_overflow;

   superstring_scoreboard_type sb;
   int unsigned beats_taken;

   greedy_superstring_length_unit #(
      .MAX_STRINGS(NUM_SLOTS),
      .SLOT_LEN   (SLOT_CHARS)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_char_code         (req_char_code),
      .req_end_of_string     (req_end_of_string),
      .req_end_of_set        (req_end_of_set),
      .rsp_valid             (rsp_valid),
      .rsp_superstring_length(rsp_superstring_length),
      .rsp_overflow          (rsp_overflow)
   );

   // clock
   initial clock = 1'b0;
   always #6 clock = ~clock;

   // result check first, then note any beat taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            sb.check_result(rsp_superstring_length, rsp_overflow);
         end
         if (start && !busy) begin
            sb.note_beat(req_char_code, req_end_of_string, req_end_of_set);
            beats_taken++;
         end
      end
   end

   // one beat, with a random and possibly empty idle gap ahead of it
   task send_beat(logic [7:0] ch, bit eos, bit eoset);
      int unsigned gap, pick;
      pick = $urandom_range(99);
      gap = (pick < 65) ? 0 : (pick < 95) ? $urandom_range(3, 1) : $urandom_range(40, 10);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start <= 1'b1;
      req_char_code <= ch;
      req_end_of_string <= eos;
      req_end_of_set <= eoset;
      do @(posedge clock); while (busy);
   endtask

   // one string of random characters from a narrow or the full byte range
   task send_string(int unsigned len, bit narrow, bit last_of_set, bit mark_end);
      logic [7:0] ch;
      for (int unsigned c = 0; c < len; c++) begin
         ch = narrow ? 8'(8'h61 + $urandom_range(2)) : 8'($urandom_range(255));
         send_beat(ch, mark_end && c == len - 1, last_of_set && c == len - 1);
      end
   endtask

   task send_random_set(int unsigned count, int unsigned max_len);
      bit narrow;
      narrow = $urandom_range(3) != 0;
      for (int unsigned s = 0; s < count; s++)
         send_string($urandom_range(max_len, 1), narrow, s == count - 1,
                     s != count - 1 || $urandom_range(4) != 0);
   endtask

   initial begin
      int unsigned pick;
      sb = new();
      sb.clear_set();
      sb.errors = 0;
      beats_taken = 0;
      start = 1'b0;
      req_char_code = 8'h00;
      req_end_of_string = 1'b0;
      req_end_of_set = 1'b0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: single character set, extremes of the byte
      send_beat(8'h00, 1'b1, 1'b1);
      send_beat(8'hFF, 1'b1, 1'b1);
      // suffix-prefix overlap
      send_beat(8'hFF, 1'b0, 1'b0);
      send_beat(8'h00, 1'b1, 1'b0);
      send_beat(8'h00, 1'b0, 1'b0);
      send_beat(8'h55, 1'b1, 1'b1);
      // contained string is absorbed
      send_beat(8'h61, 1'b0, 1'b0);
      send_beat(8'h62, 1'b0, 1'b0);
      send_beat(8'h63, 1'b1, 1'b0);
      send_beat(8'h62, 1'b1, 1'b1);
      // zero overlap still concatenates
      send_beat(8'h61, 1'b0, 1'b0);
      send_beat(8'h62, 1'b1, 1'b0);
      send_beat(8'hAA, 1'b1, 1'b1);
      // end of set closes an open string
      send_beat(8'h78, 1'b1, 1'b0);
      send_beat(8'h79, 1'b0, 1'b0);
      send_beat(8'h7A, 1'b0, 1'b1);
      // identical strings
      send_beat(8'h41, 1'b1, 1'b0);
      send_beat(8'h41, 1'b1, 1'b1);

      // random sets, with too many strings mixed in now and then
      while (beats_taken < 700) begin
         pick = $urandom_range(99);
         if (pick < 8)
            send_random_set($urandom_range(20, 17), 3);
         else if (pick < 15)
            send_random_set($urandom_range(16, 8), 4);
         else
            send_random_set($urandom_range(6, 1), 8);
      end
      @(negedge clock);
      start <= 1'b0;

      while (sb.pending_lengths.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.errors == 0 && sb.pending_lengths.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit
   initial begin
      #(12 * 20000000);
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/gssl_pkg.sv
rtl/core/gssl_ram.sv
rtl/core/gssl_datapath.sv
rtl/core/gssl_controller.sv
rtl/core/greedy_superstring_length_unit.sv
test/greedy_superstring_length_unit_tb.sv
